// ----- rtl/core/aar_pkg.sv -----
package aar_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 31;
    localparam int NORM_STAGES  = 2 + SQRT_STEPS + DIV_STEPS;

    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

    typedef struct packed {
        logic             zero;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
        logic [31:0]      ang;
        logic             flip;
    } prep_t;

    typedef struct packed {
        logic             zero;
        logic [2:0][31:0] n;
        logic [31:0]      ang;
        logic             flip;
    } norm_t;

    typedef struct packed {
        logic             zero;
        logic [2:0][31:0] n;
        logic [31:0]      c;
        logic [31:0]      s;
    } trig_t;

    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] r;
        case (i)
            0:  r = 34'sd843314857;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043837;
            3:  r = 34'sd133525159;
            4:  r = 34'sd67021687;
            5:  r = 34'sd33543516;
            6:  r = 34'sd16775851;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194283;
            9:  r = 34'sd2097149;
            10: r = 34'sd1048576;
            11: r = 34'sd524288;
            12: r = 34'sd262144;
            13: r = 34'sd131072;
            14: r = 34'sd65536;
            15: r = 34'sd32768;
            16: r = 34'sd16384;
            17: r = 34'sd8192;
            18: r = 34'sd4096;
            19: r = 34'sd2048;
            20: r = 34'sd1024;
            21: r = 34'sd512;
            22: r = 34'sd256;
            23: r = 34'sd128;
            24: r = 34'sd64;
            25: r = 34'sd32;
            26: r = 34'sd16;
            27: r = 34'sd8;
            28: r = 34'sd4;
            29: r = 34'sd2;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    // Q30 by Q30 product, rounded half up.
    function automatic logic signed [33:0] mul_q30(input logic signed [31:0] a,
                                                   input logic signed [32:0] b);
        logic signed [64:0] p;
        p = a * b;
        p = p + 65'sd536870912;
        return 34'(p >>> 30);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        logic [31:0] r;
        if (v > 36'sd2147483647)
            r = 32'h7fff_ffff;
        else if (v < -36'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ----- rtl/core/aar_prep.sv -----
module aar_prep (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  angle_rad,
    input  logic signed [31:0]  axis_x,
    input  logic signed [31:0]  axis_y,
    input  logic signed [31:0]  axis_z,
    output logic                out_valid,
    input  logic                out_ready,
    output aar_pkg::prep_t      out_data
);
    import aar_pkg::*;

    logic [1:0]        v_reg;
    logic [1:0]        v_next;
    logic [2:0]        rdy;

    logic [2:0][31:0]  mag_next;
    logic [2:0][31:0]  mag_reg;
    logic [2:0]        neg_next;
    logic [2:0]        neg_reg;
    logic [31:0]       mx_next;
    logic [31:0]       mx_reg;
    logic signed [34:0] a0;
    logic signed [34:0] a1_next;
    logic signed [34:0] a1_reg;
    logic [31:0]       ax [3];

    logic [5:0]        lz;
    logic [4:0]        k;
    prep_t             p_next;
    prep_t             p_reg;

    always_comb
    begin
        rdy[2] = out_ready;
        rdy[1] = !v_reg[1] || rdy[2];
        rdy[0] = !v_reg[0] || rdy[1];
        v_next[0] = rdy[0] ? in_valid : v_reg[0];
        v_next[1] = rdy[1] ? v_reg[0] : v_reg[1];
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[1];
    assign out_data  = p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    // First stage: magnitudes, largest magnitude, full-turn fold of the angle.
    always_comb
    begin
        ax[0] = axis_x;
        ax[1] = axis_y;
        ax[2] = axis_z;
        for (int j = 0; j < 3; j++)
        begin
            neg_next[j] = ax[j][31];
            mag_next[j] = ax[j][31] ? (~ax[j] + 32'd1) : ax[j];
        end
        mx_next = mag_next[0];
        if (mag_next[1] > mx_next)
            mx_next = mag_next[1];
        if (mag_next[2] > mx_next)
            mx_next = mag_next[2];
        a0 = {angle_rad[31], angle_rad, 2'b00};
        if (a0 > PI_Q30)
            a1_next = a0 - TWO_PI_Q30;
        else if (a0 < -PI_Q30)
            a1_next = a0 + TWO_PI_Q30;
        else
            a1_next = a0;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
            mx_reg  <= mx_next;
            a1_reg  <= a1_next;
        end
    end

    // Second stage: common left shift of the axis and half-turn fold.
    always_comb
    begin
        lz = 6'd32;
        for (int b = 0; b < 32; b++)
        begin
            if (mx_reg[b])
                lz = 6'(31 - b);
        end
        k = (lz == 6'd0) ? 5'd0 : 5'(lz - 6'd1);
        p_next.zero = (mx_reg == 32'd0);
        p_next.neg  = neg_reg;
        for (int j = 0; j < 3; j++)
            p_next.mag[j] = mag_reg[j] << k;
        if (a1_reg > HALF_PI_Q30)
        begin
            p_next.ang  = 32'(a1_reg - PI_Q30);
            p_next.flip = 1'b1;
        end
        else if (a1_reg < -HALF_PI_Q30)
        begin
            p_next.ang  = 32'(a1_reg + PI_Q30);
            p_next.flip = 1'b1;
        end
        else
        begin
            p_next.ang  = a1_reg[31:0];
            p_next.flip = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
            p_reg <= p_next;
    end

endmodule

// ----- rtl/core/aar_norm.sv -----
module aar_norm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  aar_pkg::prep_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output aar_pkg::norm_t  out_data
);
    import aar_pkg::*;

    localparam int NS = NORM_STAGES;
    localparam int SQ0 = 2;
    localparam int DV0 = 2 + SQRT_STEPS;

    logic [NS-1:0]    v_reg;
    logic [NS-1:0]    v_next;
    logic [NS:0]      rdy;

    prep_t            p_reg [NS];
    logic [2:0][63:0] sq_reg;
    logic [63:0]      sum_reg;
    logic [35:0]      rem_reg   [SQRT_STEPS];
    logic [31:0]      root_reg  [SQRT_STEPS];
    logic [63:0]      sumsh_reg [SQRT_STEPS];
    logic [31:0]      len_reg   [DIV_STEPS];
    logic [2:0][31:0] r_reg     [DIV_STEPS];
    logic [2:0][30:0] q_reg     [DIV_STEPS];

    always_comb
    begin
        rdy[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--)
            rdy[i] = !v_reg[i] || rdy[i+1];
        for (int i = 0; i < NS; i++)
        begin
            if (i == 0)
                v_next[i] = rdy[i] ? in_valid : v_reg[i];
            else
                v_next[i] = rdy[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NS; i++)
        begin
            if (rdy[i])
                p_reg[i] <= (i == 0) ? in_data : p_reg[(i == 0) ? 0 : i - 1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int j = 0; j < 3; j++)
                sq_reg[j] <= {32'd0, in_data.mag[j]} * {32'd0, in_data.mag[j]};
        end
        if (rdy[1])
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    // Floor square root, two radicand bits per stage.
    genvar g, l;
    generate
        for (g = 0; g < SQRT_STEPS; g++)
        begin : g_sqrt
            logic [35:0] rem_in;
            logic [31:0] root_in;
            logic [63:0] sumsh_in;
            logic [35:0] remx;
            logic [35:0] trial;
            if (g == 0)
            begin : g_first
                assign rem_in   = '0;
                assign root_in  = '0;
                assign sumsh_in = sum_reg;
            end
            else
            begin : g_rest
                assign rem_in   = rem_reg[g-1];
                assign root_in  = root_reg[g-1];
                assign sumsh_in = sumsh_reg[g-1];
            end
            assign remx  = {rem_in[33:0], sumsh_in[63:62]};
            assign trial = {2'b00, root_in, 2'b01};
            always_ff @(posedge clk)
            begin
                if (rdy[SQ0+g])
                begin
                    sumsh_reg[g] <= sumsh_in << 2;
                    if (remx >= trial)
                    begin
                        rem_reg[g]  <= remx - trial;
                        root_reg[g] <= {root_in[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[g]  <= remx;
                        root_reg[g] <= {root_in[30:0], 1'b0};
                    end
                end
            end
        end

        // Restoring division of each magnitude by the length, one quotient bit per stage.
        for (g = 0; g < DIV_STEPS; g++)
        begin : g_div
            logic [31:0] len_in;
            if (g == 0)
            begin : g_first
                assign len_in = root_reg[SQRT_STEPS-1];
            end
            else
            begin : g_rest
                assign len_in = len_reg[g-1];
            end
            always_ff @(posedge clk)
            begin
                if (rdy[DV0+g])
                    len_reg[g] <= len_in;
            end
            for (l = 0; l < 3; l++)
            begin : g_lane
                logic [32:0] rx;
                logic [30:0] q_in;
                if (g == 0)
                begin : g_first
                    assign rx   = {1'b0, p_reg[DV0-1].mag[l]};
                    assign q_in = '0;
                end
                else
                begin : g_rest
                    assign rx   = {r_reg[g-1][l], 1'b0};
                    assign q_in = q_reg[g-1][l];
                end
                always_ff @(posedge clk)
                begin
                    if (rdy[DV0+g])
                    begin
                        if (rx >= {1'b0, len_in})
                        begin
                            r_reg[g][l] <= 32'(rx - {1'b0, len_in});
                            q_reg[g][l] <= {q_in[29:0], 1'b1};
                        end
                        else
                        begin
                            r_reg[g][l] <= rx[31:0];
                            q_reg[g][l] <= {q_in[29:0], 1'b0};
                        end
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        out_data.zero = p_reg[NS-1].zero;
        out_data.ang  = p_reg[NS-1].ang;
        out_data.flip = p_reg[NS-1].flip;
        for (int j = 0; j < 3; j++)
        begin
            if (p_reg[NS-1].neg[j])
                out_data.n[j] = -{1'b0, q_reg[DIV_STEPS-1][j]};
            else
                out_data.n[j] = {1'b0, q_reg[DIV_STEPS-1][j]};
        end
    end

endmodule

// ----- rtl/core/aar_cordic.sv -----
module aar_cordic (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  aar_pkg::norm_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output aar_pkg::trig_t  out_data
);
    import aar_pkg::*;

    localparam int NS = CORDIC_STEPS + 1;

    logic [NS-1:0]      v_reg;
    logic [NS-1:0]      v_next;
    logic [NS:0]        rdy;

    norm_t              pn_reg [CORDIC_STEPS];
    logic signed [33:0] x_reg  [CORDIC_STEPS];
    logic signed [33:0] y_reg  [CORDIC_STEPS];
    logic signed [33:0] z_reg  [CORDIC_STEPS];
    trig_t              t_next;
    trig_t              t_reg;
    logic signed [33:0] xc;
    logic signed [33:0] yc;

    always_comb
    begin
        rdy[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--)
            rdy[i] = !v_reg[i] || rdy[i+1];
        for (int i = 0; i < NS; i++)
        begin
            if (i == 0)
                v_next[i] = rdy[i] ? in_valid : v_reg[i];
            else
                v_next[i] = rdy[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    genvar g;
    generate
        for (g = 0; g < CORDIC_STEPS; g++)
        begin : g_step
            norm_t              pn_in;
            logic signed [33:0] x_in;
            logic signed [33:0] y_in;
            logic signed [33:0] z_in;
            if (g == 0)
            begin : g_first
                assign pn_in = in_data;
                assign x_in  = GAIN_Q30;
                assign y_in  = '0;
                assign z_in  = {{2{in_data.ang[31]}}, in_data.ang};
            end
            else
            begin : g_rest
                assign pn_in = pn_reg[g-1];
                assign x_in  = x_reg[g-1];
                assign y_in  = y_reg[g-1];
                assign z_in  = z_reg[g-1];
            end
            always_ff @(posedge clk)
            begin
                if (rdy[g])
                begin
                    pn_reg[g] <= pn_in;
                    if (!z_in[33])
                    begin
                        x_reg[g] <= x_in - (y_in >>> g);
                        y_reg[g] <= y_in + (x_in >>> g);
                        z_reg[g] <= z_in - atan_q30(g);
                    end
                    else
                    begin
                        x_reg[g] <= x_in + (y_in >>> g);
                        y_reg[g] <= y_in - (x_in >>> g);
                        z_reg[g] <= z_in + atan_q30(g);
                    end
                end
            end
        end
    endgenerate

    // Clamp to the unit range and undo the half-turn fold.
    always_comb
    begin
        xc = x_reg[CORDIC_STEPS-1];
        yc = y_reg[CORDIC_STEPS-1];
        if (xc > ONE_Q30)
            xc = ONE_Q30;
        else if (xc < -ONE_Q30)
            xc = -ONE_Q30;
        if (yc > ONE_Q30)
            yc = ONE_Q30;
        else if (yc < -ONE_Q30)
            yc = -ONE_Q30;
        if (pn_reg[CORDIC_STEPS-1].flip)
        begin
            xc = -xc;
            yc = -yc;
        end
        t_next.zero = pn_reg[CORDIC_STEPS-1].zero;
        t_next.n    = pn_reg[CORDIC_STEPS-1].n;
        t_next.c    = xc[31:0];
        t_next.s    = yc[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NS-1])
            t_reg <= t_next;
    end

endmodule

// ----- rtl/core/aar_matrix.sv -----
module aar_matrix (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  aar_pkg::trig_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [8:0][31:0] m,
    output logic            status
);
    import aar_pkg::*;

    logic [2:0]         v_reg;
    logic [2:0]         v_next;
    logic [3:0]         rdy;

    logic signed [31:0] n0, n1, n2, cin;
    logic [5:0][31:0]   nn_reg;
    logic [2:0][31:0]   sn_reg;
    logic signed [32:0] t_reg;
    logic [31:0]        c_reg;
    logic               zero_reg;

    logic [5:0][33:0]   pt_reg;
    logic [2:0][31:0]   sn1_reg;
    logic [31:0]        c1_reg;
    logic               zero1_reg;

    logic signed [35:0] p [6];
    logic signed [35:0] sn [3];
    logic signed [35:0] cc;
    logic [8:0][31:0]   m_next;
    logic [8:0][31:0]   m_reg;
    logic               status_reg;

    always_comb
    begin
        rdy[3] = out_ready;
        for (int i = 2; i >= 0; i--)
            rdy[i] = !v_reg[i] || rdy[i+1];
        v_next[0] = rdy[0] ? in_valid : v_reg[0];
        v_next[1] = rdy[1] ? v_reg[0] : v_reg[1];
        v_next[2] = rdy[2] ? v_reg[1] : v_reg[2];
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[2];
    assign m         = m_reg;
    assign status    = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign n0  = in_data.n[0];
    assign n1  = in_data.n[1];
    assign n2  = in_data.n[2];
    assign cin = in_data.c;

    // Products of the axis components: xx, yy, zz, xy, xz, yz; and sine times each.
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            nn_reg[0] <= 32'(mul_q30(n0, 33'(n0)));
            nn_reg[1] <= 32'(mul_q30(n1, 33'(n1)));
            nn_reg[2] <= 32'(mul_q30(n2, 33'(n2)));
            nn_reg[3] <= 32'(mul_q30(n0, 33'(n1)));
            nn_reg[4] <= 32'(mul_q30(n0, 33'(n2)));
            nn_reg[5] <= 32'(mul_q30(n1, 33'(n2)));
            sn_reg[0] <= 32'(mul_q30($signed(in_data.s), 33'(n0)));
            sn_reg[1] <= 32'(mul_q30($signed(in_data.s), 33'(n1)));
            sn_reg[2] <= 32'(mul_q30($signed(in_data.s), 33'(n2)));
            t_reg     <= 33'(ONE_Q30) - 33'(cin);
            c_reg     <= in_data.c;
            zero_reg  <= in_data.zero;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            for (int j = 0; j < 6; j++)
                pt_reg[j] <= mul_q30($signed(nn_reg[j]), t_reg);
            sn1_reg   <= sn_reg;
            c1_reg    <= c_reg;
            zero1_reg <= zero_reg;
        end
    end

    always_comb
    begin
        for (int j = 0; j < 6; j++)
            p[j] = 36'($signed(pt_reg[j]));
        for (int j = 0; j < 3; j++)
            sn[j] = 36'($signed(sn1_reg[j]));
        cc = 36'($signed(c1_reg));
        m_next[0] = sat32(p[0] + cc);
        m_next[1] = sat32(p[3] - sn[2]);
        m_next[2] = sat32(p[4] + sn[1]);
        m_next[3] = sat32(p[3] + sn[2]);
        m_next[4] = sat32(p[1] + cc);
        m_next[5] = sat32(p[5] - sn[0]);
        m_next[6] = sat32(p[4] - sn[1]);
        m_next[7] = sat32(p[5] + sn[0]);
        m_next[8] = sat32(p[2] + cc);
        // A zero-length axis gives the identity whatever the angle.
        if (zero1_reg)
        begin
            m_next    = '0;
            m_next[0] = ONE_Q30[31:0];
            m_next[4] = ONE_Q30[31:0];
            m_next[8] = ONE_Q30[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            m_reg      <= m_next;
            status_reg <= zero1_reg;
        end
    end

endmodule

// ----- rtl/core/axis_angle_rotation_matrix.sv -----
// Rodrigues axis-angle rotation matrix. Each request carries a Q3.28 angle and a Q16.16 axis
// of any nonzero length; the result is the nine Q2.30 entries of the 3x3 rotation, row-major,
// with status 0, or the identity with status 1 when all axis components are zero. The block
// is a fully pipelined datapath that takes one request per clock while in_stall is low; it runs
// from preparation through normalization and CORDIC to the matrix, with the one-bit-per-stage
// square root (32 stages) and axis division (31 stages) as its longest parts. Each stage
// advances on its own, so empty stages close up while the output is stalled and requests keep
// being taken until the pipeline is full.
module axis_angle_rotation_matrix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] angle_rad,
    input  logic signed [31:0] axis_x,
    input  logic signed [31:0] axis_y,
    input  logic signed [31:0] axis_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] m00,
    output logic signed [31:0] m01,
    output logic signed [31:0] m02,
    output logic signed [31:0] m10,
    output logic signed [31:0] m11,
    output logic signed [31:0] m12,
    output logic signed [31:0] m20,
    output logic signed [31:0] m21,
    output logic signed [31:0] m22,
    output logic               status
);
    import aar_pkg::*;

    logic             prep_ready;
    logic             prep_valid;
    prep_t            prep_data;
    logic             norm_ready;
    logic             norm_valid;
    norm_t            norm_data;
    logic             trig_ready;
    logic             trig_valid;
    trig_t            trig_data;
    logic             mat_ready;
    logic [8:0][31:0] m;

    assign in_stall = !prep_ready;

    aar_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (prep_ready),
        .angle_rad (angle_rad),
        .axis_x    (axis_x),
        .axis_y    (axis_y),
        .axis_z    (axis_z),
        .out_valid (prep_valid),
        .out_ready (norm_ready),
        .out_data  (prep_data)
    );

    aar_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (norm_ready),
        .in_data   (prep_data),
        .out_valid (norm_valid),
        .out_ready (trig_ready),
        .out_data  (norm_data)
    );

    aar_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (norm_valid),
        .in_ready  (trig_ready),
        .in_data   (norm_data),
        .out_valid (trig_valid),
        .out_ready (mat_ready),
        .out_data  (trig_data)
    );

    aar_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (trig_valid),
        .in_ready  (mat_ready),
        .in_data   (trig_data),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .m         (m),
        .status    (status)
    );

    assign m00 = m[0];
    assign m01 = m[1];
    assign m02 = m[2];
    assign m10 = m[3];
    assign m11 = m[4];
    assign m12 = m[5];
    assign m20 = m[6];
    assign m21 = m[7];
    assign m22 = m[8];

endmodule

// ----- tb/rotation_checker.sv -----
`timescale 1ns / 100ps

module rotation_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] angle_rad,
    input  logic signed [31:0] axis_x,
    input  logic signed [31:0] axis_y,
    input  logic signed [31:0] axis_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] m00,
    input  logic signed [31:0] m01,
    input  logic signed [31:0] m02,
    input  logic signed [31:0] m10,
    input  logic signed [31:0] m11,
    input  logic signed [31:0] m12,
    input  logic signed [31:0] m20,
    input  logic signed [31:0] m21,
    input  logic signed [31:0] m22,
    input  logic               status,
    output int                 fail_count,
    output int                 pending,
    output int                 matrices_seen,
    output int                 zero_axis_seen
);

    typedef struct {
        logic signed [31:0] m [9];
        logic               zero;
    } rot_t;

    rot_t matrix_queue[$];

    localparam longint UNIT    = 64'sd1073741824;
    localparam longint HALF    = 64'sd536870912;
    localparam longint PI      = 64'sd3373259426;
    localparam longint HALF_PI = 64'sd1686629713;
    localparam longint TWO_PI  = 64'sd6746518852;
    localparam longint GAIN    = 64'sd652032874;

    longint arc_table [30] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
    };

    function automatic longint fix_mul(longint a, longint b);
        return (a * b + HALF) >>> 30;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic rot_t predict_rotation(logic signed [31:0] ang_in,
                                              logic signed [31:0] ax [3]);
        rot_t r;
        longint unsigned mag [3];
        longint unsigned mx, sum, len;
        longint n [3];
        longint ang, x, y, z, dx, dy, c, s, t, xx, yy, zz, xy, xz, yz;
        longint e [9];
        bit flip;
        int k;
        mx = 0;
        sum = 0;
        flip = 0;
        for (int j = 0; j < 3; j++)
        begin
            mag[j] = ax[j] < 0 ? -longint'(ax[j]) : longint'(ax[j]);
            if (mag[j] > mx)
                mx = mag[j];
        end
        r.zero = (mx == 0);
        if (r.zero)
        begin
            foreach (r.m[j])
                r.m[j] = (j % 4 == 0) ? 32'sd1073741824 : 32'sd0;
            return r;
        end
        k = 0;
        while (mx < (64'd1 << 30) && k < 31)
        begin
            mx <<= 1;
            k++;
        end
        for (int j = 0; j < 3; j++)
        begin
            mag[j] <<= k;
            sum += mag[j] * mag[j];
        end
        len = root_floor(sum);
        for (int j = 0; j < 3; j++)
        begin
            n[j] = longint'((mag[j] << 30) / len);
            if (ax[j] < 0)
                n[j] = -n[j];
        end
        ang = longint'(ang_in) * 4;
        if (ang > PI)
            ang -= TWO_PI;
        else if (ang < -PI)
            ang += TWO_PI;
        if (ang > HALF_PI)
        begin
            ang -= PI;
            flip = 1;
        end
        else if (ang < -HALF_PI)
        begin
            ang += PI;
            flip = 1;
        end
        x = GAIN;
        y = 0;
        z = ang;
        for (int i = 0; i < aar_pkg::CORDIC_STEPS && i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= arc_table[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += arc_table[i];
            end
        end
        c = x > UNIT ? UNIT : (x < -UNIT ? -UNIT : x);
        s = y > UNIT ? UNIT : (y < -UNIT ? -UNIT : y);
        if (flip)
        begin
            c = -c;
            s = -s;
        end
        t = UNIT - c;
        xx = fix_mul(n[0], n[0]);
        yy = fix_mul(n[1], n[1]);
        zz = fix_mul(n[2], n[2]);
        xy = fix_mul(n[0], n[1]);
        xz = fix_mul(n[0], n[2]);
        yz = fix_mul(n[1], n[2]);
        e[0] = fix_mul(xx, t) + c;
        e[1] = fix_mul(xy, t) - fix_mul(s, n[2]);
        e[2] = fix_mul(xz, t) + fix_mul(s, n[1]);
        e[3] = fix_mul(xy, t) + fix_mul(s, n[2]);
        e[4] = fix_mul(yy, t) + c;
        e[5] = fix_mul(yz, t) - fix_mul(s, n[0]);
        e[6] = fix_mul(xz, t) - fix_mul(s, n[1]);
        e[7] = fix_mul(yz, t) + fix_mul(s, n[0]);
        e[8] = fix_mul(zz, t) + c;
        foreach (e[j])
            r.m[j] = clip32(e[j]);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rot_t want;
        logic signed [31:0] ax [3];
        logic signed [31:0] got [9];
        if (!rst_n)
        begin
            fail_count <= 0;
            matrices_seen <= 0;
            zero_axis_seen <= 0;
            pending <= 0;
            matrix_queue.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
                if (matrix_queue.size() == 0)
                    report_mismatch("unexpected result, queue depth", 0, 1);
                else
                begin
                    want = matrix_queue.pop_front();
                    for (int j = 0; j < 9; j++)
                        if (got[j] !== want.m[j])
                            report_mismatch($sformatf("m%0d%0d", j / 3, j % 3),
                                            got[j], want.m[j]);
                    if (status !== want.zero)
                        report_mismatch("status", status, want.zero);
                    if (want.zero)
                        zero_axis_seen <= zero_axis_seen + 1;
                end
                matrices_seen <= matrices_seen + 1;
            end
            if (in_valid && !in_stall)
            begin
                ax = '{axis_x, axis_y, axis_z};
                matrix_queue.push_back(predict_rotation(angle_rad, ax));
            end
            pending <= matrix_queue.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    localparam int LATENCY     = 2 + aar_pkg::NORM_STAGES + aar_pkg::CORDIC_STEPS + 1 + 3;
    localparam int RANDOM_REQS = 1100;
    localparam int CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] angle_rad;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic               status;
    int                 fail_count;
    int                 pending;
    int                 matrices_seen;
    int                 zero_axis_seen;
    int                 cycle_count;
    int                 requests_sent;
    bit                 hold_off;

    axis_angle_rotation_matrix uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .angle_rad(angle_rad), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22), .status(status)
    );

    rotation_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .angle_rad(angle_rad), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22), .status(status),
        .fail_count(fail_count), .pending(pending),
        .matrices_seen(matrices_seen), .zero_axis_seen(zero_axis_seen)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycle_count, pending);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Receiver: a long hold-off early on, then random stalls with calm stretches.
    initial
    begin
        int mode;
        out_stall = 1'b0;
        hold_off = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
                out_stall <= 1'b0;
            end
            else
            begin
                mode = (cycle_count / 500) % 3;
                if (mode == 0)
                    out_stall <= 1'b0;
                else if (mode == 1)
                    out_stall <= ($urandom_range(0, 3) == 0);
                else
                    out_stall <= ($urandom_range(0, 1) == 0);
            end
        end
    end

    function automatic logic signed [31:0] random_axis();
        case ($urandom_range(0, 6))
            0: return 32'sd0;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2: return $signed($urandom_range(0, 7)) - 32'sd3;
            3: return $signed($urandom) >>> $urandom_range(0, 31);
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] random_angle();
        case ($urandom_range(0, 5))
            0: return 32'sd843314856 + $signed($urandom_range(0, 4)) - 32'sd2;
            1: return -32'sd843314856 + $signed($urandom_range(0, 4)) - 32'sd2;
            2: return 32'sd421657428 + $signed($urandom_range(0, 4)) - 32'sd2;
            3: return -32'sd421657428 + $signed($urandom_range(0, 4)) - 32'sd2;
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic send_request(logic signed [31:0] a, logic signed [31:0] x,
                                logic signed [31:0] y, logic signed [31:0] z);
        in_valid  <= 1'b1;
        angle_rad <= a;
        axis_x    <= x;
        axis_y    <= y;
        axis_z    <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    initial
    begin
        logic signed [31:0] angles [12];
        int burst;
        in_valid  = 1'b0;
        angle_rad = '0;
        axis_x    = '0;
        axis_y    = '0;
        axis_z    = '0;
        requests_sent = 0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Folding edges: exactly pi and half pi (Q3.28 rounds these), the range ends, zero.
        angles = '{32'sd0, 32'sh7fffffff, 32'sh80000000, 32'sd843314856, 32'sd843314857,
                   -32'sd843314856, -32'sd843314857, 32'sd421657428, 32'sd421657429,
                   -32'sd421657428, -32'sd421657429, 32'sd1};
        foreach (angles[i])
            send_request(angles[i], 32'sd65536 * (i % 3 == 0), 32'sd65536 * (i % 3 == 1),
                         32'sd65536 * (i % 3 == 2));
        send_request(32'sd12345678, 32'sd0, 32'sd0, 32'sd0);
        send_request(32'sh7fffffff, 32'sd0, 32'sd0, 32'sd0);
        send_request(32'sd300000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_request(32'sd300000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_request(-32'sd300000000, 32'sh80000000, 32'sh7fffffff, 32'sd1);
        send_request(32'sd200000000, 32'sd1, 32'sd0, 32'sd0);
        send_request(32'sd200000000, 32'sd0, -32'sd1, 32'sd0);
        send_request(32'sd200000000, 32'sd1, 32'sd1, -32'sd1);
        send_request(32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 32'shffffffff);
        send_request(32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 32'sh00000001);

        // Stall the output for a long time while requests keep coming.
        hold_off = 1'b1;
        repeat (200)
            send_request(random_angle(), random_axis(), random_axis(), random_axis());
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);

        while (requests_sent < RANDOM_REQS)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst)
                send_request(random_angle(), random_axis(), random_axis(), random_axis());
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        wait (pending == 0);
        repeat (LATENCY + 10) @(posedge clk);
        $display("Sent %0d requests; %0d matrices checked, %0d with a zero axis.",
                 requests_sent, matrices_seen, zero_axis_seen);
        $display("Angle folding edges, extreme axes and a long output stall were included.");
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/aar_pkg.sv
rtl/core/aar_prep.sv
rtl/core/aar_norm.sv
rtl/core/aar_cordic.sv
rtl/core/aar_matrix.sv
rtl/core/axis_angle_rotation_matrix.sv
tb/rotation_checker.sv
tb/tb_top.sv
